FILE: hdl/erld_pkg.sv
`timescale 1ns / 1ps
// erld_pkg: constants and types shared by the escape run-length decoder
// no dependencies; used by hdl/escape_run_length_decoder.sv

package erld_pkg;

    // marker bytes of the compressed page format
    localparam logic [7:0] EscByte  = 8'hED;
    localparam logic [7:0] ZeroByte = 8'h00;

    // bytes held in the look-ahead window, and results one byte can cause
    localparam int WindowDepth = 3;
    localparam int MaxResults  = 4;

    // result queue sized so a full burst fits behind a backlog of MaxResults
    localparam int QueueDepth  = 2 * MaxResults;
    localparam int QueueCntW   = $clog2(QueueDepth + 1);
    localparam int ResCntW     = $clog2(MaxResults + 1);

    // register map (word index taken from paddr[2])
    localparam logic RegCompressedMode = 1'b0;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] count;
        logic       last;
    } t_result;

endpackage

FILE: hdl/escape_run_length_decoder.sv
`timescale 1ns / 1ps
// escape_run_length_decoder: byte-at-a-time escape run-length page decoder
// output: an accepted byte's results are registered into the result queue and offered behind the entries already in it
// throughput: one byte per cycle while the result queue holds at most four results;
//   a byte that causes several results drains them one per cycle from the queue while i_out_ready is high
// reset (i_rst_n low, synchronous): window and queue emptied, stop cleared, compressed_mode = 1
// depends on hdl/erld_pkg.sv

module escape_run_length_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_page_end,
    // run output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_value,
    output logic [7:0]  o_out_count,
    output logic        o_out_last
);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic r_mode;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == erld_pkg::RegCompressedMode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (cfg_wr) begin
            r_mode <= pwdata[0];
        end
    end

    // reads return the mode bit at its word, zero elsewhere
    assign prdata = (paddr[2] == erld_pkg::RegCompressedMode) ? {31'd0, r_mode} : 32'd0;

    // ------------------------------------------------------------------
    // window state: held bytes oldest first, their count, and the stop flag
    // set by the end-of-page sequence
    // ------------------------------------------------------------------
    logic [7:0] r_held [erld_pkg::WindowDepth];
    logic [7:0] n_held [erld_pkg::WindowDepth];
    logic [1:0] r_held_cnt, n_held_cnt;
    logic       r_stopped, n_stopped;

    // result queue: entry 0 is the head and drives the output ports
    erld_pkg::t_result              r_q [erld_pkg::QueueDepth];
    erld_pkg::t_result              n_q [erld_pkg::QueueDepth];
    logic [erld_pkg::QueueCntW-1:0] r_q_cnt, n_q_cnt;

    logic in_acc;
    logic out_acc;

    // room for a full burst of results is what lets the next byte in
    assign o_in_ready  = (r_q_cnt <= erld_pkg::QueueCntW'(erld_pkg::QueueDepth - erld_pkg::MaxResults));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_q_cnt != '0);
    assign out_acc     = o_out_valid && i_out_ready;

    assign o_out_value = r_q[0].value;
    assign o_out_count = r_q[0].count;
    assign o_out_last  = r_q[0].last;

    // ------------------------------------------------------------------
    // single-pass decode of the window plus the incoming byte
    // ------------------------------------------------------------------
    logic [7:0]                   win [erld_pkg::MaxResults];
    logic [2:0]                   win_total;
    logic                         is_stop_seq;
    logic                         is_escape;
    erld_pkg::t_result            res [erld_pkg::MaxResults];
    logic [erld_pkg::ResCntW-1:0] res_n;

    always_comb begin
        // window: held bytes first, incoming byte right behind them
        for (int i = 0; i < erld_pkg::MaxResults; i++) begin
            win[i] = (i < erld_pkg::WindowDepth && 2'(i) < r_held_cnt) ?
                     r_held[i < erld_pkg::WindowDepth ? i : 0] : i_data_byte;
        end
        win_total = {1'b0, r_held_cnt} + 3'd1;

        is_stop_seq = (win_total == 3'd4) && (win[0] == erld_pkg::ZeroByte)
                   && (win[1] == erld_pkg::EscByte) && (win[2] == erld_pkg::EscByte)
                   && (win[3] == erld_pkg::ZeroByte);
        is_escape   = (win_total == 3'd4) && (win[0] == erld_pkg::EscByte)
                   && (win[1] == erld_pkg::EscByte);

        // defaults: no results, state unchanged
        for (int i = 0; i < erld_pkg::MaxResults; i++) begin
            res[i] = '{value: win[i], count: 8'd1, last: 1'b0};
        end
        res_n      = '0;
        n_held_cnt = r_held_cnt;
        n_stopped  = r_stopped;
        for (int i = 0; i < erld_pkg::WindowDepth; i++) begin
            n_held[i] = r_held[i];
        end

        if (r_stopped) begin
            // page already ended: swallow bytes, marker on the last one
            if (i_page_end) begin
                res[0]     = '{value: 8'd0, count: 8'd0, last: 1'b1};
                res_n      = erld_pkg::ResCntW'(1);
                n_stopped  = 1'b0;
                n_held_cnt = 2'd0;
            end
        end else if (!r_mode || i_page_end && !is_stop_seq && !is_escape) begin
            // flush the whole window as literals, last one marked at page end
            for (int i = 0; i < erld_pkg::MaxResults; i++) begin
                res[i].last = i_page_end && (3'(i) == win_total - 3'd1);
            end
            res_n      = erld_pkg::ResCntW'(win_total);
            n_held_cnt = 2'd0;
        end else if (is_stop_seq) begin
            // end-of-page sequence: marker now, or stop until the last byte
            n_held_cnt = 2'd0;
            if (i_page_end) begin
                res[0] = '{value: 8'd0, count: 8'd0, last: 1'b1};
                res_n  = erld_pkg::ResCntW'(1);
            end else begin
                n_stopped = 1'b1;
            end
        end else if (is_escape) begin
            // escape run; a zero-length run emits nothing but the marker at page end
            n_held_cnt = 2'd0;
            if (win[2] != 8'd0) begin
                res[0] = '{value: win[3], count: win[2], last: i_page_end};
                res_n  = erld_pkg::ResCntW'(1);
            end else if (i_page_end) begin
                res[0] = '{value: 8'd0, count: 8'd0, last: 1'b1};
                res_n  = erld_pkg::ResCntW'(1);
            end
        end else if (win_total == 3'd4) begin
            // full window, no match: oldest byte leaves as a literal
            res_n = erld_pkg::ResCntW'(1);
            for (int i = 0; i < erld_pkg::WindowDepth; i++) begin
                n_held[i] = win[i + 1];
            end
            n_held_cnt = 2'd3;
        end else begin
            // window not yet full: just hold the byte
            for (int i = 0; i < erld_pkg::WindowDepth; i++) begin
                n_held[i] = win[i];
            end
            n_held_cnt = win_total[1:0];
        end
    end

    // ------------------------------------------------------------------
    // result queue: pop shifts toward the head, new results land behind
    // the entries that remain
    // ------------------------------------------------------------------
    logic [erld_pkg::QueueCntW-1:0] q_base;
    logic [erld_pkg::QueueCntW-1:0] q_off [erld_pkg::QueueDepth];

    always_comb begin
        q_base = r_q_cnt - erld_pkg::QueueCntW'(out_acc);
        for (int j = 0; j < erld_pkg::QueueDepth; j++) begin
            q_off[j] = erld_pkg::QueueCntW'(j) - q_base;
        end
        for (int j = 0; j < erld_pkg::QueueDepth - 1; j++) begin
            n_q[j] = out_acc ? r_q[j + 1] : r_q[j];
        end
        n_q[erld_pkg::QueueDepth - 1] = r_q[erld_pkg::QueueDepth - 1];
        for (int j = 0; j < erld_pkg::QueueDepth; j++) begin
            if (in_acc && erld_pkg::QueueCntW'(j) >= q_base
                    && q_off[j] < erld_pkg::QueueCntW'(res_n)) begin
                n_q[j] = res[q_off[j][1:0]];
            end
        end
        n_q_cnt = q_base + (in_acc ? erld_pkg::QueueCntW'(res_n) : '0);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_stopped  <= 1'b0;
            r_q_cnt    <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
            if (in_acc) begin
                r_held_cnt <= n_held_cnt;
                r_stopped  <= n_stopped;
            end
        end
    end

    // payload: held bytes and queue entries
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < erld_pkg::WindowDepth; i++) begin
                r_held[i] <= n_held[i];
            end
        end
        for (int j = 0; j < erld_pkg::QueueDepth; j++) begin
            r_q[j] <= n_q[j];
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= erld_pkg::QueueCntW'(erld_pkg::QueueDepth))
        else $error("result queue overflow");

    // a stopped page never keeps bytes in the window
    a_stop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_held_cnt == 2'd0))
        else $error("window not empty while page stopped");

    // a zero count is only the final marker
    a_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_count == 8'd0) |-> o_out_last)
        else $error("zero-count result not marked last");

    // pass-through mode leaves nothing held
    a_pass_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_mode) |=> (r_held_cnt == 2'd0))
        else $error("bytes held after pass-through transaction");

endmodule
